// ===== hw/rtl/plk_pkg.sv =====
package plk_pkg;

    localparam int unsigned OUT_W = 7;

    localparam logic [1:0] MODE_ACQUIRE     = 2'd0;
    localparam logic [1:0] MODE_RELEASE     = 2'd1;
    localparam logic [1:0] MODE_RELEASE_ALL = 2'd2;
    localparam logic [1:0] MODE_CHECK       = 2'd3;

    localparam logic [31:0] WHOLE_RELATION = 32'hFFFF_FFFF;
    localparam logic [15:0] WHOLE_PAGE     = 16'd0;

    typedef struct packed {
        logic [31:0] rel;
        logic [31:0] blk;
        logic [15:0] off;
        logic [31:0] xid;
    } t_entry;

    typedef struct packed {
        logic xid_eq;
        logic tag_eq;
        logic covers;
    } t_match;

endpackage

// ===== hw/rtl/plk_store.sv =====
module plk_store #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = 6
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [AW-1:0]        i_wr_addr,
    input  plk_pkg::t_entry      i_wr_data,
    input  logic                 i_rd_en,
    input  logic [AW-1:0]        i_rd_addr,
    output plk_pkg::t_entry      o_rd_data
);

    plk_pkg::t_entry r_mem [DEPTH];
    plk_pkg::t_entry r_rd_data;

    // One write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/plk_match.sv =====
module plk_match (
    input  plk_pkg::t_entry i_entry,
    input  plk_pkg::t_entry i_probe,
    output plk_pkg::t_match o_match
);

    logic rel_eq;
    logic blk_eq;
    logic off_eq;

    assign rel_eq = (i_entry.rel == i_probe.rel);
    assign blk_eq = (i_entry.blk == i_probe.blk);
    assign off_eq = (i_entry.off == i_probe.off);

    assign o_match.xid_eq = (i_entry.xid == i_probe.xid);
    assign o_match.tag_eq = rel_eq && blk_eq && off_eq;
    // Whole-relation entry covers any block; whole-page entry covers any offset.
    assign o_match.covers = rel_eq &&
                            ((i_entry.blk == plk_pkg::WHOLE_RELATION) ||
                             (blk_eq && ((i_entry.off == plk_pkg::WHOLE_PAGE) || off_eq)));

endmodule

// ===== hw/rtl/predicate_lock_table.sv =====
// Acquire, release and check scan every table entry, then pass through a finish state; o_done
// is registered from the finish state, and the next start is taken once the block is idle again.
// Release-all skips the scan and goes straight from start to the finish state.
// One operation at a time; the scan reads one table entry per cycle through the
// single read port of the entry memory and the shared compare unit.
// Synchronous active-low reset clears valid bits and held count; the receiver cannot stall.
module predicate_lock_table #(
    parameter int unsigned CAPACITY = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_mode,
    input  logic [31:0] i_rel_id,
    input  logic [31:0] i_block_number,
    input  logic [15:0] i_tuple_offset,
    input  logic [31:0] i_transaction_id,
    output logic        o_done,
    output logic        o_conflict,
    output logic [6:0]  o_removed_count,
    output logic [6:0]  o_held_count,
    output logic        o_table_full
);

    // Index width for the table, count width that can hold CAPACITY itself.
    localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    // Control state
    logic [1:0]          r_state,     n_state;
    logic [CW-1:0]       r_idx,       n_idx;
    logic                r_pv,        n_pv;
    logic [IW-1:0]       r_pidx,      n_pidx;
    logic [CAPACITY-1:0] r_valid,     n_valid;
    logic [CW-1:0]       r_count,     n_count;
    logic                r_dup,       n_dup;
    logic                r_have_free, n_have_free;
    logic [IW-1:0]       r_free,      n_free;
    logic [CW-1:0]       r_removed,   n_removed;
    logic                r_conflict,  n_conflict;
    logic                r_done,      n_done;

    // Captured operation and result payload
    logic [1:0]          r_mode;
    plk_pkg::t_entry     r_probe;
    logic                r_o_conflict, n_o_conflict;
    logic [CW-1:0]       r_o_removed,  n_o_removed;
    logic [CW-1:0]       r_o_held,     n_o_held;
    logic                r_o_full,     n_o_full;

    logic                accept;
    logic                rd_en;
    logic                wr_en;
    plk_pkg::t_entry     rd_data;
    plk_pkg::t_match     match;
    logic [CW+6:0]       removed_ext;
    logic [CW+6:0]       held_ext;

    assign accept = start && (r_state == ST_IDLE);
    assign busy   = (r_state != ST_IDLE);

    plk_store #(
        .DEPTH (CAPACITY),
        .AW    (IW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_free),
        .i_wr_data (r_probe),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_idx[IW-1:0]),
        .o_rd_data (rd_data)
    );

    // Shared compare unit: one table entry against the captured probe per cycle.
    plk_match u_match (
        .i_entry (rd_data),
        .i_probe (r_probe),
        .o_match (match)
    );

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_pv         = 1'b0;
        n_pidx       = r_pidx;
        n_valid      = r_valid;
        n_count      = r_count;
        n_dup        = r_dup;
        n_have_free  = r_have_free;
        n_free       = r_free;
        n_removed    = r_removed;
        n_conflict   = r_conflict;
        n_done       = 1'b0;
        n_o_conflict = r_o_conflict;
        n_o_removed  = r_o_removed;
        n_o_held     = r_o_held;
        n_o_full     = r_o_full;
        rd_en        = 1'b0;
        wr_en        = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_idx       = '0;
                    n_dup       = 1'b0;
                    n_have_free = 1'b0;
                    n_removed   = '0;
                    n_conflict  = 1'b0;
                    if (i_mode == plk_pkg::MODE_RELEASE_ALL) begin
                        // Every valid entry goes at once; the count is the tally.
                        n_removed = r_count;
                        n_valid   = '0;
                        n_count   = '0;
                        n_state   = ST_DONE;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end

            ST_SCAN: begin
                // Issue stage: read the next entry while any remain.
                rd_en = (r_idx != CW'(CAPACITY));
                if (rd_en) begin
                    n_idx = r_idx + CW'(1);
                end
                n_pv   = rd_en;
                n_pidx = r_idx[IW-1:0];

                // Evaluate stage: the entry read in the previous cycle.
                if (r_pv) begin
                    if (r_valid[r_pidx]) begin
                        case (r_mode)
                            plk_pkg::MODE_ACQUIRE: begin
                                if (match.tag_eq && match.xid_eq) begin
                                    n_dup = 1'b1;
                                end
                            end
                            plk_pkg::MODE_RELEASE: begin
                                if (match.xid_eq) begin
                                    n_valid[r_pidx] = 1'b0;
                                    n_removed       = r_removed + CW'(1);
                                end
                            end
                            plk_pkg::MODE_CHECK: begin
                                if (match.covers) begin
                                    n_conflict = 1'b1;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end else if (!r_have_free) begin
                        // Lowest free slot wins.
                        n_have_free = 1'b1;
                        n_free      = r_pidx;
                    end
                end

                if (r_idx == CW'(CAPACITY)) begin
                    n_state = ST_DONE;
                end
            end

            ST_DONE: begin
                n_o_full = 1'b0;
                if (r_mode == plk_pkg::MODE_ACQUIRE && !r_dup) begin
                    if (r_have_free) begin
                        wr_en           = 1'b1;
                        n_valid[r_free] = 1'b1;
                        n_count         = r_count + CW'(1);
                    end else begin
                        n_o_full = 1'b1;
                    end
                end
                if (r_mode == plk_pkg::MODE_RELEASE) begin
                    n_count = r_count - r_removed;
                end
                n_o_conflict = r_conflict;
                n_o_removed  = r_removed;
                n_o_held     = n_count;
                n_done       = 1'b1;
                n_state      = ST_IDLE;
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_pv        <= 1'b0;
            r_pidx      <= '0;
            r_valid     <= '0;
            r_count     <= '0;
            r_dup       <= 1'b0;
            r_have_free <= 1'b0;
            r_free      <= '0;
            r_removed   <= '0;
            r_conflict  <= 1'b0;
            r_done      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_pv        <= n_pv;
            r_pidx      <= n_pidx;
            r_valid     <= n_valid;
            r_count     <= n_count;
            r_dup       <= n_dup;
            r_have_free <= n_have_free;
            r_free      <= n_free;
            r_removed   <= n_removed;
            r_conflict  <= n_conflict;
            r_done      <= n_done;
        end
    end

    // Hold the operation for the whole scan; hold results until the next one.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode      <= i_mode;
            r_probe.rel <= i_rel_id;
            r_probe.blk <= i_block_number;
            r_probe.off <= i_tuple_offset;
            r_probe.xid <= i_transaction_id;
        end
        r_o_conflict <= n_o_conflict;
        r_o_removed  <= n_o_removed;
        r_o_held     <= n_o_held;
        r_o_full     <= n_o_full;
    end

    // Counts leave as 7 bits: zero-extend small tables, truncate large ones.
    assign removed_ext = {{7{1'b0}}, r_o_removed};
    assign held_ext    = {{7{1'b0}}, r_o_held};

    assign o_done          = r_done;
    assign o_conflict      = r_o_conflict;
    assign o_removed_count = removed_ext[plk_pkg::OUT_W-1:0];
    assign o_held_count    = held_ext[plk_pkg::OUT_W-1:0];
    assign o_table_full    = r_o_full;

    // A taken transfer always starts an operation.
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transfer did not raise busy");

    // A result strobe only comes as the block goes idle again.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy && $past(r_state) == ST_DONE)
        else $error("result strobe outside the end of an operation");

    // Between operations the held count matches the valid bits.
    a_count_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_count == CW'($countones(r_valid))))
        else $error("held count disagrees with valid bits");

    // The count never exceeds the table size.
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("held count above capacity");

    // A dropped acquire means every entry was in use.
    a_full_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_table_full) |-> (r_valid == {CAPACITY{1'b1}}))
        else $error("table_full with a free entry");

endmodule
